// File: hw/rtl/ready_queue_policy_select_macros.svh
// assertion macros for the ready queue
`ifndef READY_QUEUE_POLICY_SELECT_MACROS_SVH
`define READY_QUEUE_POLICY_SELECT_MACROS_SVH
`define RQPS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: check failed");
`define RQPS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

// File: hw/rtl/rqps_pkg.sv
// ---------------------------------------------------------------------------
// rqps_pkg
// types and codes shared by the ready queue cells and control
// ---------------------------------------------------------------------------
package rqps_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_ASK    = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam logic [1:0] POL_RR     = 2'd0;
    localparam logic [1:0] POL_BURST  = 2'd1;
    localparam logic [1:0] POL_REM    = 2'd2;
    localparam logic [1:0] POL_PRIO   = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] remaining;
    } entry_t;

    // candidate travelling along the chain
    typedef struct packed {
        logic   valid;
        entry_t ent;
    } cand_t;

    // control from sequencer to cells
    typedef struct packed {
        logic       scan;
        logic [1:0] key;
        logic       first;
    } cell_ctl_t;

    // true when a comes before b under the selection order
    function automatic logic better(input entry_t a, input entry_t b, input logic [1:0] key);
        logic [15:0] ka;
        logic [15:0] kb;
        logic        tie;
        ka = (key == POL_BURST) ? a.burst : a.remaining;
        kb = (key == POL_BURST) ? b.burst : b.remaining;
        if (a.arrival != b.arrival) tie = a.arrival < b.arrival;
        else if (a.prio != b.prio) tie = a.prio > b.prio;
        else tie = a.id < b.id;
        if (key == POL_PRIO)
        begin
            if (a.prio != b.prio) return a.prio > b.prio;
            return tie;
        end
        if (ka != kb) return ka < kb;
        return tie;
    endfunction
endpackage

// File: hw/rtl/rqps_cell.sv
// ---------------------------------------------------------------------------
// rqps_cell
// one queue slot: holds an entry and forwards the best candidate seen so far
// ---------------------------------------------------------------------------
module rqps_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  rqps_pkg::entry_t    wr_ent,
    input  logic                occ,
    input  rqps_pkg::cell_ctl_t ctl,
    input  rqps_pkg::cand_t     cand_in,
    output rqps_pkg::cand_t     cand_out,
    output logic                is_best,
    input  logic                take_next,
    input  rqps_pkg::entry_t    next_ent,
    output rqps_pkg::entry_t    ent
);
    rqps_pkg::entry_t ent_reg;
    rqps_pkg::cand_t  cand_reg;
    rqps_pkg::cand_t  cand_next;
    logic             win;

    assign win = occ && (!cand_in.valid || ctl.first ||
                         rqps_pkg::better(ent_reg, cand_in.ent, ctl.key));

    always_comb
    begin
        cand_next = cand_in;
        if (win) cand_next = '{valid: 1'b1, ent: ent_reg};
    end

    // a cell marks itself best when it overrides the incoming candidate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
            is_best  <= 1'b0;
        end
        else if (ctl.scan)
        begin
            cand_reg <= cand_next;
            is_best  <= win;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) ent_reg <= wr_ent;
        else if (take_next) ent_reg <= next_ent;
    end

    assign cand_out = cand_reg;
    assign ent      = ent_reg;
endmodule

// File: hw/rtl/ready_queue_policy_select.sv
// ---------------------------------------------------------------------------
// ready_queue_policy_select
// scheduler ready queue with round robin, shortest burst, shortest remaining
// and priority selection
// ---------------------------------------------------------------------------
// Entries sit in a row of cells in arrival order. Insert writes the slot after
// the last unless the queue is full. Pop and ask pass a best candidate down
// the row one cell per cycle; the closing shift after a pop happens at once on
// every cell from the winner onward, in the cycle that captures the result.
// The result beat is held in an output register; the next command is accepted
// once it has been taken, so a stall on the result side delays that command.
module ready_queue_policy_select
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0] proc_id[9:2] arrival_time[25:10] prio[33:26] burst_time[49:34]
    // remaining_time[65:50], zero fill to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_valid[0] chosen_id[8:1] chosen_arrival[24:9] chosen_prio[32:25]
    // chosen_burst[48:33] chosen_remaining[64:49] preempt[65] overflow[66]
    // ready_count[71:67]
    output logic [71:0] m_tdata
);
    `include "ready_queue_policy_select_macros.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_DONE = 3'd2,
                           ST_OUT = 3'd3;

    logic [2:0]       st_reg;
    logic [1:0]       policy_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    step_reg;
    logic [1:0]       cmd_reg;
    logic [15:0]      cur_reg;
    rqps_pkg::entry_t in_ent_reg;
    logic [71:0]      out_reg;
    logic [71:0]      out_next;

    rqps_pkg::cand_t     chain [QUEUE_DEPTH+1];
    rqps_pkg::entry_t    ents  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] best, occ, shift;
    logic [QUEUE_DEPTH-1:0] best_last;
    rqps_pkg::cell_ctl_t ctl;
    logic [QUEUE_DEPTH-1:0] found;

    assign cfg_ready = (st_reg == ST_IDLE) && !m_tvalid;
    assign s_tready  = (st_reg == ST_IDLE) && !m_tvalid;
    assign m_tvalid  = (st_reg == ST_OUT);
    assign m_tdata   = out_reg;
    assign chain[0]  = '0;

    always_comb
    begin
        ctl.scan  = (st_reg == ST_SCAN);
        ctl.first = 1'b0;
        ctl.key   = (cmd_reg == rqps_pkg::CMD_ASK) ? rqps_pkg::POL_REM : policy_reg;
    end

    // winner's position: last cell that overrode the candidate; head on RR pop
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            found[i] = best[i];
            for (int j = i + 1; j < QUEUE_DEPTH; j++)
                if (best[j]) found[i] = 1'b0;
        end
        if (cmd_reg == rqps_pkg::CMD_POP && policy_reg == rqps_pkg::POL_RR)
        begin
            found = '0;
            found[0] = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            assign occ[g] = (CW'(g) < count_reg);
            if (g == 0)
            begin : g_head
                assign best_last[g] = found[g];
            end
            else
            begin : g_tail
                assign best_last[g] = found[g] | best_last[g-1];
            end
            assign shift[g] = (st_reg == ST_DONE) && (cmd_reg == rqps_pkg::CMD_POP) &&
                              best_last[g] && (CW'(g + 1) < count_reg);
            rqps_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     ((st_reg == ST_DONE) && (cmd_reg == rqps_pkg::CMD_INSERT) &&
                            (count_reg < CW'(QUEUE_DEPTH)) && (count_reg == CW'(g))),
                .wr_ent    (in_ent_reg),
                .occ       (occ[g]),
                .ctl       (ctl),
                .cand_in   (chain[g]),
                .cand_out  (chain[g+1]),
                .is_best   (best[g]),
                .take_next (shift[g]),
                .next_ent  (ents[(g + 1 < QUEUE_DEPTH) ? g + 1 : g]),
                .ent       (ents[g])
            );
        end
    endgenerate

    rqps_pkg::entry_t pick;
    always_comb
    begin
        pick = ents[0];
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (found[i]) pick = ents[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            policy_reg <= rqps_pkg::POL_RR;
            count_reg  <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) policy_reg <= cfg_data;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        step_reg <= '0;
                        st_reg   <= (s_tdata[1:0] == rqps_pkg::CMD_INSERT) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == IW'(QUEUE_DEPTH - 1)) st_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    st_reg <= ST_OUT;
                    if (cmd_reg == rqps_pkg::CMD_INSERT && count_reg < CW'(QUEUE_DEPTH))
                        count_reg <= count_reg + 1'b1;
                    else if (cmd_reg == rqps_pkg::CMD_POP && count_reg != '0)
                        count_reg <= count_reg - 1'b1;
                end
                ST_OUT:
                begin
                    if (m_tready) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    logic [CW-1:0] cnt_after;
    always_comb
    begin
        cnt_after = count_reg;
        if (cmd_reg == rqps_pkg::CMD_INSERT && count_reg < CW'(QUEUE_DEPTH))
            cnt_after = count_reg + 1'b1;
        else if (cmd_reg == rqps_pkg::CMD_POP && count_reg != '0)
            cnt_after = count_reg - 1'b1;
    end

    always_comb
    begin
        out_next = '0;
        out_next[71:67] = 5'(cnt_after);
        if (cmd_reg == rqps_pkg::CMD_INSERT)
            out_next[66] = (count_reg >= CW'(QUEUE_DEPTH));
        if (cmd_reg == rqps_pkg::CMD_POP && count_reg != '0)
            out_next[64:0] = {pick.remaining, pick.burst, pick.prio, pick.arrival,
                              pick.id, 1'b1};
        if (cmd_reg == rqps_pkg::CMD_ASK && count_reg != '0)
            out_next[65] = (chain[QUEUE_DEPTH].ent.remaining < cur_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg    <= s_tdata[1:0];
            in_ent_reg <= '{id: s_tdata[9:2], arrival: s_tdata[25:10], prio: s_tdata[33:26],
                            burst: s_tdata[49:34], remaining: s_tdata[65:50]};
            cur_reg    <= s_tdata[65:50];
        end
        if (st_reg == ST_DONE)
            out_reg <= out_next;
    end

    `RQPS_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `RQPS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_reg != ST_IDLE, !s_tready)
    `RQPS_ASSERT_NXT(a_done_to_out, clk, rst_n, st_reg == ST_DONE, m_tvalid)
endmodule
